// ----- rtl/core/ddrle_pkg.sv -----
// ============================================================================
// ddrle_pkg - shared types and constants for the decimal digit RLE unit
// Holds the digit-split constants, the run length cap and the queue entry type
// used by the front end, the digit queue and the back end.
// ============================================================================
package ddrle_pkg;

    // Stream sizing
    localparam int MAX_ITEMS   = 128;
    localparam int COUNT_LIMIT = 2047;
    localparam int RUN_CAP_INT = (10 * MAX_ITEMS > COUNT_LIMIT) ? COUNT_LIMIT : 10 * MAX_ITEMS;

    // Field widths
    localparam int VALUE_W = 31;
    localparam int DIGIT_W = 4;
    localparam int COUNT_W = 11;

    localparam logic [COUNT_W-1:0] RUN_CAP = COUNT_W'(RUN_CAP_INT);

    // Digit split: floor(v / 10) == (v * DIV10_MUL) >> DIV10_SHIFT for 32-bit v
    localparam int          MAX_DIGITS  = 10;
    localparam int          DIG_IDX_W   = $clog2(MAX_DIGITS);
    localparam logic [31:0] DIV10_MUL   = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;
    localparam int          PROD_W      = VALUE_W + 32;
    localparam int          QUOT_W      = PROD_W - DIV10_SHIFT;

    // Digit queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // One digit in flight from front to back; flush marks the final digit of a stream
    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               flush;
    } ddrle_digit_t;

    // Front end sequencer states
    typedef enum logic [2:0] {
        FR_IDLE = 3'b001,
        FR_CONV = 3'b010,
        FR_PUSH = 3'b100
    } ddrle_front_state_t;

endpackage

// ----- rtl/core/ddrle_front.sv -----
// ============================================================================
// ddrle_front - value intake and decimal digit split
// Accepts one value, peels off one decimal digit per cycle (least significant
// first) into a small buffer, then pushes the digits most significant first.
// ============================================================================
module ddrle_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ddrle_pkg::VALUE_W-1:0]     s_value,
    input  logic                              s_last,
    // digit queue write side
    output logic                              push,
    output ddrle_pkg::ddrle_digit_t           push_data,
    input  logic                              full
);

    ddrle_pkg::ddrle_front_state_t state_reg, state_next;

    logic [ddrle_pkg::VALUE_W-1:0]   val_reg, val_next;
    logic                            last_reg, last_next;
    logic [ddrle_pkg::DIG_IDX_W-1:0] idx_reg, idx_next;
    logic [ddrle_pkg::DIGIT_W-1:0]   dig_buf_reg [ddrle_pkg::MAX_DIGITS];

    logic [ddrle_pkg::PROD_W-1:0]    prod;
    logic [ddrle_pkg::QUOT_W-1:0]    quot;
    logic [ddrle_pkg::VALUE_W-1:0]   quot10;
    logic [ddrle_pkg::VALUE_W-1:0]   rem_full;
    logic [ddrle_pkg::DIGIT_W-1:0]   rem;
    logic                            dig_wr;

    // divide by ten through the reciprocal, remainder by shift-add
    assign prod     = ddrle_pkg::PROD_W'(val_reg) * ddrle_pkg::PROD_W'(ddrle_pkg::DIV10_MUL);
    assign quot     = prod[ddrle_pkg::PROD_W-1:ddrle_pkg::DIV10_SHIFT];
    assign quot10   = {quot, 3'b000} + {2'b00, quot, 1'b0};
    assign rem_full = val_reg - quot10;
    assign rem      = rem_full[ddrle_pkg::DIGIT_W-1:0];

    assign s_tready = (state_reg == ddrle_pkg::FR_IDLE);
    assign dig_wr   = (state_reg == ddrle_pkg::FR_CONV);

    // queue write: buffer read back from the top digit down
    assign push            = (state_reg == ddrle_pkg::FR_PUSH);
    assign push_data.digit = dig_buf_reg[idx_reg];
    assign push_data.flush = last_reg && (idx_reg == '0);

    // sequencer
    always_comb begin
        state_next = state_reg;
        val_next   = val_reg;
        last_next  = last_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ddrle_pkg::FR_IDLE: begin
                if (s_tvalid) begin
                    val_next   = s_value;
                    last_next  = s_last;
                    idx_next   = '0;
                    state_next = ddrle_pkg::FR_CONV;
                end
            end
            ddrle_pkg::FR_CONV: begin
                val_next = {{(ddrle_pkg::VALUE_W - ddrle_pkg::QUOT_W){1'b0}}, quot};
                // quotient zero: this was the top digit, idx stays on it
                if (quot == '0) begin
                    state_next = ddrle_pkg::FR_PUSH;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ddrle_pkg::FR_PUSH: begin
                if (!full) begin
                    if (idx_reg == '0) begin
                        state_next = ddrle_pkg::FR_IDLE;
                    end else begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            default: begin
                state_next = ddrle_pkg::FR_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ddrle_pkg::FR_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        val_reg  <= val_next;
        last_reg <= last_next;
        if (dig_wr) begin
            dig_buf_reg[idx_reg] <= rem;
        end
    end

endmodule

// ----- rtl/core/ddrle_fifo.sv -----
// ============================================================================
// ddrle_fifo - short digit queue between front and back
// Register-based FIFO so that digit split and pair emission stall apart.
// ============================================================================
module ddrle_fifo (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  ddrle_pkg::ddrle_digit_t push_data,
    output logic                    full,
    input  logic                    pop,
    output ddrle_pkg::ddrle_digit_t pop_data,
    output logic                    empty
);

    ddrle_pkg::ddrle_digit_t         mem_reg [ddrle_pkg::FIFO_DEPTH];
    logic [ddrle_pkg::FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [ddrle_pkg::FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [ddrle_pkg::FIFO_AW:0]     count_reg, count_next;
    logic                            do_push, do_pop;

    assign full     = (count_reg == (ddrle_pkg::FIFO_AW+1)'(ddrle_pkg::FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/core/ddrle_back.sv -----
// ============================================================================
// ddrle_back - run tracking and pair emission
// Takes one digit per cycle from the queue when the output is free and no
// flush is pending, extends or closes the open run and drives the output
// register. A flush digit closing an older run leaves the final pair pending.
// ============================================================================
module ddrle_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    // digit queue read side
    input  ddrle_pkg::ddrle_digit_t         pop_data,
    input  logic                            empty,
    output logic                            pop,
    // output stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ddrle_pkg::DIGIT_W-1:0]   m_digit,
    output logic [ddrle_pkg::COUNT_W-1:0]   m_run_length,
    output logic                            m_last
);

    logic [ddrle_pkg::DIGIT_W-1:0] run_digit_reg, run_digit_next;
    logic [ddrle_pkg::COUNT_W-1:0] run_count_reg, run_count_next;
    logic                          run_open_reg, run_open_next;
    logic                          flush_pend_reg, flush_pend_next;

    logic                          m_valid_reg, m_valid_next;
    logic [ddrle_pkg::DIGIT_W-1:0] out_digit_reg, out_digit_next;
    logic [ddrle_pkg::COUNT_W-1:0] out_len_reg, out_len_next;
    logic                          out_last_reg, out_last_next;

    logic                          out_free;
    logic                          load;
    logic                          extend;
    logic [ddrle_pkg::COUNT_W-1:0] cnt_inc;

    assign out_free = !m_valid_reg || m_tready;
    assign extend   = run_open_reg && (pop_data.digit == run_digit_reg)
                      && (run_count_reg < ddrle_pkg::RUN_CAP);
    assign cnt_inc  = run_count_reg + 1'b1;
    assign pop      = out_free && !flush_pend_reg && !empty;

    // run update and pair selection
    always_comb begin
        run_digit_next  = run_digit_reg;
        run_count_next  = run_count_reg;
        run_open_next   = run_open_reg;
        flush_pend_next = flush_pend_reg;
        load            = 1'b0;
        out_digit_next  = out_digit_reg;
        out_len_next    = out_len_reg;
        out_last_next   = out_last_reg;

        if (out_free && flush_pend_reg) begin
            // final pair of a stream after an older run closed
            load            = 1'b1;
            out_digit_next  = run_digit_reg;
            out_len_next    = run_count_reg;
            out_last_next   = 1'b1;
            run_digit_next  = '0;
            run_count_next  = '0;
            run_open_next   = 1'b0;
            flush_pend_next = 1'b0;
        end else if (pop) begin
            if (extend) begin
                if (pop_data.flush) begin
                    load           = 1'b1;
                    out_digit_next = run_digit_reg;
                    out_len_next   = cnt_inc;
                    out_last_next  = 1'b1;
                    run_digit_next = '0;
                    run_count_next = '0;
                    run_open_next  = 1'b0;
                end else begin
                    run_count_next = cnt_inc;
                end
            end else if (run_open_reg) begin
                // close the old run, open a new one
                load            = 1'b1;
                out_digit_next  = run_digit_reg;
                out_len_next    = run_count_reg;
                out_last_next   = 1'b0;
                run_digit_next  = pop_data.digit;
                run_count_next  = ddrle_pkg::COUNT_W'(1);
                run_open_next   = 1'b1;
                flush_pend_next = pop_data.flush;
            end else if (pop_data.flush) begin
                // single digit stream end with nothing open
                load           = 1'b1;
                out_digit_next = pop_data.digit;
                out_len_next   = ddrle_pkg::COUNT_W'(1);
                out_last_next  = 1'b1;
                run_digit_next = '0;
                run_count_next = '0;
                run_open_next  = 1'b0;
            end else begin
                run_digit_next = pop_data.digit;
                run_count_next = ddrle_pkg::COUNT_W'(1);
                run_open_next  = 1'b1;
            end
        end

        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_digit_reg  <= '0;
            run_count_reg  <= '0;
            run_open_reg   <= 1'b0;
            flush_pend_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            run_digit_reg  <= run_digit_next;
            run_count_reg  <= run_count_next;
            run_open_reg   <= run_open_next;
            flush_pend_reg <= flush_pend_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        out_digit_reg <= out_digit_next;
        out_len_reg   <= out_len_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid     = m_valid_reg;
    assign m_digit      = out_digit_reg;
    assign m_run_length = out_len_reg;
    assign m_last       = out_last_reg;

endmodule

// ----- rtl/core/decimal_digit_run_length_encoder_unit.sv -----
// ============================================================================
// decimal_digit_run_length_encoder_unit - run-length encoder over digits
// Top level: front end digit split, digit queue, back end pair emission.
// ============================================================================
// A value on the input stream is split into decimal digits, most significant
// first (zero gives the digit 0); digits of all values form one sequence and
// each finished run of equal digits leaves as a (digit, run length) pair. The
// beat with tlast set flushes the open run, and that pair carries tlast. Runs
// are capped at 1280; a longer stretch of equal digits continues as a new run.
// The front end splits a value into digits by the divide-by-ten step, one
// digit per cycle, then pushes them into the queue, one per cycle while it
// is not full, and only then takes a new value. The back end takes one
// digit per cycle while the output is free and no flush is pending, and
// emits at most one pair per cycle; a stream end closing an older run leaves
// its final pair pending. A four-entry digit queue lets the two sides stall
// apart; the output register holds a pair while the next value is taken in.
module decimal_digit_run_length_encoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] value, [31] zero pad
    input  logic        s_tlast,   // last_item
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [3:0] digit, [14:4] run_length, [15] zero pad
    output logic        m_tlast    // last_pair
);

    ddrle_pkg::ddrle_digit_t         push_data;
    ddrle_pkg::ddrle_digit_t         pop_data;
    logic                            push, full, pop, empty;
    logic [ddrle_pkg::DIGIT_W-1:0]   m_digit;
    logic [ddrle_pkg::COUNT_W-1:0]   m_run_length;

    ddrle_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_value   (s_tdata[ddrle_pkg::VALUE_W-1:0]),
        .s_last    (s_tlast),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    ddrle_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    ddrle_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pop_data     (pop_data),
        .empty        (empty),
        .pop          (pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_digit      (m_digit),
        .m_run_length (m_run_length),
        .m_last       (m_tlast)
    );

    assign m_tdata = {1'b0, m_run_length, m_digit};

endmodule

// ----- rtl/core/ddrle_checker.sv -----
// ============================================================================
// ddrle_checker - port-level checks for the digit RLE unit
// Watches the input handshake, and the result stream for held beats and
// in-range pair fields.
// ============================================================================
module ddrle_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // an accepted value keeps the input closed while its digits are split
    a_in_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted beat");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // digit is decimal
    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[3:0] <= 4'd9)
        else $error("digit out of range");

    // run length within one and the cap
    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[14:4] != 11'd0) && (m_tdata[14:4] <= ddrle_pkg::RUN_CAP))
        else $error("run length out of range");

    // pad bit stays clear
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[15])
        else $error("result pad bit set");

endmodule

bind decimal_digit_run_length_encoder_unit ddrle_checker u_ddrle_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
